### design/hfe_pkg.sv
// ----------------------------------------------------------------------------
// hfe_pkg: shared types and constants
// Field widths, register indexes and the command/status bundles between
// the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package hfe_pkg;
    localparam int SAMPLE_W = 16;
    localparam int BPU_W    = 9;
    localparam int TEMP_W   = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int DENS_W   = 25;
    localparam int FE_W     = 32;
    localparam int LN_W     = 21;
    localparam int FMAG_W   = 29;

    localparam int DEF_MAX_SAMPLES = 4096;
    localparam int DEF_MAX_BINS    = 64;

    localparam logic [CFG_IDX_W-1:0] REG_BPU  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP = 1'd1;

    localparam logic [BPU_W-1:0]  BPU_RESET  = 9'd10;
    localparam logic [TEMP_W-1:0] TEMP_RESET = 16'd256;
    localparam logic [DENS_W-1:0] DENS_MAX   = 25'h1FFFFFF;
    localparam logic [31:0]       LN2_Q32    = 32'd2977044472;

    typedef struct packed {
        logic load;
        logic setup;
        logic run_clear;
        logic clr_wr;
        logic fill_rd_idx;
        logic fill_rd_bin;
        logic fill_wr;
        logic emit_rd;
        logic div_init;
        logic div_step;
        logic norm_init;
        logic norm_step;
        logic log_step;
        logic ln_mul;
        logic fe_mul;
        logic out_emit;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic clr_last;
        logic fill_last;
        logic bin_zero;
        logic div_done;
        logic norm_done;
        logic log_done;
        logic emit_last;
    } t_sts;
endpackage
`default_nettype wire

### design/hfe_ram.sv
// ----------------------------------------------------------------------------
// hfe_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module hfe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### design/hfe_ctrl.sv
// ----------------------------------------------------------------------------
// hfe_ctrl: run sequencer
// Steps through set-up, bin clear, fill and the per-bin result pass.
// ----------------------------------------------------------------------------
`default_nettype none
module hfe_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_last,
    input  wire hfe_pkg::t_sts i_sts,
    output      hfe_pkg::t_cmd o_cmd,
    output      logic          o_busy
);
    import hfe_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SETUP  = 4'd1;
    localparam logic [3:0] S_CLEAR  = 4'd2;
    localparam logic [3:0] S_FILL_A = 4'd3;
    localparam logic [3:0] S_FILL_B = 4'd4;
    localparam logic [3:0] S_FILL_C = 4'd5;
    localparam logic [3:0] S_EMIT_A = 4'd6;
    localparam logic [3:0] S_EMIT_B = 4'd7;
    localparam logic [3:0] S_DIV    = 4'd8;
    localparam logic [3:0] S_SAT    = 4'd9;
    localparam logic [3:0] S_NORM   = 4'd10;
    localparam logic [3:0] S_LOG    = 4'd11;
    localparam logic [3:0] S_LN     = 4'd12;
    localparam logic [3:0] S_FE     = 4'd13;
    localparam logic [3:0] S_OUT    = 4'd14;

    logic [3:0] r_state, n_state;

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_start;
                if (i_start && i_last) n_state = S_SETUP;
            end
            S_SETUP: begin
                if (i_sts.empty) begin
                    o_cmd.run_clear = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.setup = 1'b1;
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) n_state = S_FILL_A;
            end
            S_FILL_A: begin
                o_cmd.fill_rd_idx = 1'b1;
                n_state = S_FILL_B;
            end
            S_FILL_B: begin
                o_cmd.fill_rd_bin = 1'b1;
                n_state = S_FILL_C;
            end
            S_FILL_C: begin
                o_cmd.fill_wr = 1'b1;
                n_state = i_sts.fill_last ? S_EMIT_A : S_FILL_A;
            end
            S_EMIT_A: begin
                o_cmd.emit_rd = 1'b1;
                n_state = S_EMIT_B;
            end
            S_EMIT_B: begin
                o_cmd.div_init = 1'b1;
                n_state = i_sts.bin_zero ? S_OUT : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) n_state = S_SAT;
            end
            S_SAT: begin
                o_cmd.norm_init = 1'b1;
                n_state = S_NORM;
            end
            S_NORM: begin
                if (i_sts.norm_done) begin
                    n_state = S_LOG;
                end else begin
                    o_cmd.norm_step = 1'b1;
                end
            end
            S_LOG: begin
                o_cmd.log_step = 1'b1;
                if (i_sts.log_done) n_state = S_LN;
            end
            S_LN: begin
                o_cmd.ln_mul = 1'b1;
                n_state = S_FE;
            end
            S_FE: begin
                o_cmd.fe_mul = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_cmd.out_emit = 1'b1;
                if (i_sts.emit_last) begin
                    o_cmd.run_clear = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_EMIT_A;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

### design/hfe_dp.sv
// ----------------------------------------------------------------------------
// hfe_dp: histogram datapath
// Quantiser, sample and bin stores, divider, log2 unit and output stage.
// ----------------------------------------------------------------------------
`default_nettype none
module hfe_dp #(
    parameter int MAX_SAMPLES = hfe_pkg::DEF_MAX_SAMPLES,
    parameter int MAX_BINS    = hfe_pkg::DEF_MAX_BINS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire hfe_pkg::t_cmd                       i_cmd,
    output      hfe_pkg::t_sts                       o_sts,
    input  wire logic                                i_cfg_we,
    input  wire logic [hfe_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [hfe_pkg::CFG_W-1:0]           i_cfg_data,
    input  wire logic signed [hfe_pkg::SAMPLE_W-1:0] i_sample,
    output      logic                                o_valid,
    output      logic signed [15:0]                  o_bin_index,
    output      logic [hfe_pkg::DENS_W-1:0]          o_density,
    output      logic signed [hfe_pkg::FE_W-1:0]     o_free_energy,
    output      logic                                o_overflow,
    output      logic                                o_last_bin
);
    import hfe_pkg::*;

    localparam int AW  = $clog2(MAX_SAMPLES);
    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int KW  = $clog2(MAX_BINS);
    localparam int NBW = $clog2(MAX_BINS + 1);
    localparam int PW  = CW + BPU_W;
    localparam int NW  = PW + 16;
    localparam int ITW = $clog2(NW);

    // configuration
    logic [BPU_W-1:0]  r_bpu;
    logic [TEMP_W-1:0] r_temp;
    logic [BPU_W-1:0]  bpu_eff;

    // run state
    logic [CW-1:0]        r_count;
    logic signed [15:0]   r_min, r_max;
    logic                 r_ovf;
    logic [NBW-1:0]       r_nb;
    logic [KW-1:0]        r_k, r_off;
    logic [AW-1:0]        r_i;

    // arithmetic
    logic [NW-1:0]     r_dvd;
    logic [CW-1:0]     r_rem;
    logic [ITW-1:0]    r_it;
    logic              r_zero;
    logic [31:0]       r_m;
    logic [4:0]        r_p;
    logic [15:0]       r_frac;
    logic              r_neg;
    logic [LN_W-1:0]   r_ln;
    logic [FMAG_W-1:0] r_fmag;
    logic [DENS_W-1:0] r_dens;

    // quantiser
    logic signed [25:0] q_prod;
    logic signed [17:0] q_wide;
    logic signed [15:0] q_idx;
    logic               q_sat;

    assign bpu_eff = (r_bpu == '0) ? BPU_W'(1) : r_bpu;
    assign q_prod  = i_sample * $signed({1'b0, bpu_eff});
    assign q_wide  = q_prod[25:8];
    always_comb begin
        q_sat = 1'b0;
        q_idx = q_wide[15:0];
        if (q_wide > 18'sd32767) begin
            q_idx = 16'sh7FFF;
            q_sat = 1'b1;
        end else if (q_wide < -18'sd32768) begin
            q_idx = -16'sh8000;
            q_sat = 1'b1;
        end
    end

    logic store_ok;
    assign store_ok = (r_count < CW'(MAX_SAMPLES));

    // span: full index range gives 65536, so one bit beyond 17 signed
    logic signed [17:0] span;
    assign span = 18'(r_max) - 18'(r_min) + 18'sd1;

    // stores
    logic [15:0] idx_rdata;
    logic [CW-1:0] bin_rdata;
    logic          bin_we;
    logic [KW-1:0] bin_waddr, bin_raddr;
    logic [CW-1:0] bin_wdata;
    logic [16:0]   off_wide;
    logic [KW-1:0] off;

    assign off_wide = 17'($signed(idx_rdata)) - 17'(r_min);
    assign off = (off_wide >= 17'(r_nb)) ? KW'(r_nb - NBW'(1)) : off_wide[KW-1:0];

    hfe_ram #(.WIDTH(16), .DEPTH(MAX_SAMPLES)) u_idx_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && store_ok),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (q_idx),
        .i_raddr (r_i),
        .o_rdata (idx_rdata)
    );

    assign bin_we    = i_cmd.clr_wr || i_cmd.fill_wr;
    assign bin_waddr = i_cmd.clr_wr ? r_k : r_off;
    assign bin_wdata = i_cmd.clr_wr ? '0 : bin_rdata + CW'(1);
    assign bin_raddr = i_cmd.fill_rd_bin ? off : r_k;

    hfe_ram #(.WIDTH(CW), .DEPTH(MAX_BINS)) u_bin_ram (
        .i_clk   (i_clk),
        .i_we    (bin_we),
        .i_waddr (bin_waddr),
        .i_wdata (bin_wdata),
        .i_raddr (bin_raddr),
        .o_rdata (bin_rdata)
    );

    // divider step
    logic [CW:0]   rem2;
    logic          qbit;
    assign rem2 = {r_rem, r_dvd[NW-1]};
    assign qbit = (rem2 >= {1'b0, r_count});

    // log2 squaring step
    logic [63:0] sq;
    logic [32:0] sq_top;
    assign sq     = r_m * r_m;
    assign sq_top = sq[63:31];

    // ln and free energy
    logic [5:0]         p_off;
    logic signed [31:0] l_val;
    logic [31:0]        l_abs;
    logic [52:0]        ln_prod;
    logic [36:0]        fe_prod;
    logic [31:0]        fe_val;
    assign p_off   = {1'b0, r_p} - 6'd16;
    assign l_val   = {{10{p_off[5]}}, p_off, r_frac};
    assign l_abs   = l_val[31] ? 32'(-l_val) : 32'(l_val);
    assign ln_prod = 53'(l_abs[LN_W-1:0]) * 53'(LN2_Q32) + 53'h80000000;
    assign fe_prod = 37'(r_temp) * 37'(r_ln) + 37'd128;
    assign fe_val  = r_neg ? 32'(r_fmag) : 32'(0) - 32'(r_fmag);

    // status
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.clr_last  = (NBW'(r_k) == r_nb - NBW'(1));
    assign o_sts.fill_last = (CW'(r_i) == r_count - CW'(1));
    assign o_sts.bin_zero  = (bin_rdata == '0);
    assign o_sts.div_done  = (r_it == ITW'(NW - 1));
    assign o_sts.norm_done = r_m[31];
    assign o_sts.log_done  = (r_it == ITW'(15));
    assign o_sts.emit_last = o_sts.clr_last;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpu   <= BPU_RESET;
            r_temp  <= TEMP_RESET;
            r_count <= '0;
            r_min   <= 16'sh7FFF;
            r_max   <= -16'sh8000;
            r_ovf   <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.out_emit;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BPU:  r_bpu  <= i_cfg_data[BPU_W-1:0];
                    REG_TEMP: r_temp <= i_cfg_data[TEMP_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                if (q_sat) r_ovf <= 1'b1;
                if (store_ok) begin
                    r_count <= r_count + CW'(1);
                    if (q_idx < r_min) r_min <= q_idx;
                    if (q_idx > r_max) r_max <= q_idx;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.setup && span > 18'(MAX_BINS)) r_ovf <= 1'b1;
            if (i_cmd.run_clear) begin
                r_count <= '0;
                r_min   <= 16'sh7FFF;
                r_max   <= -16'sh8000;
                r_ovf   <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_nb <= (span > 18'(MAX_BINS)) ? NBW'(MAX_BINS) : span[NBW-1:0];
            r_k  <= '0;
            r_i  <= '0;
        end
        if (i_cmd.clr_wr || i_cmd.out_emit) begin
            r_k <= o_sts.clr_last ? '0 : r_k + KW'(1);
        end
        if (i_cmd.fill_rd_bin) r_off <= off;
        if (i_cmd.fill_wr) r_i <= r_i + AW'(1);
        if (i_cmd.div_init) begin
            r_dvd  <= {PW'(bin_rdata) * PW'(bpu_eff), 16'd0};
            r_rem  <= '0;
            r_it   <= '0;
            r_zero <= (bin_rdata == '0);
        end
        if (i_cmd.div_step) begin
            r_rem <= qbit ? CW'(rem2 - {1'b0, r_count}) : rem2[CW-1:0];
            r_dvd <= {r_dvd[NW-2:0], qbit};
            r_it  <= r_it + ITW'(1);
        end
        if (i_cmd.norm_init) begin
            r_dens <= (r_dvd > NW'(DENS_MAX)) ? DENS_MAX : r_dvd[DENS_W-1:0];
            r_m    <= (r_dvd > NW'(DENS_MAX)) ? 32'(DENS_MAX) : 32'(r_dvd[DENS_W-1:0]);
            r_p    <= 5'd31;
            r_it   <= '0;
            r_frac <= '0;
        end
        if (i_cmd.norm_step) begin
            r_m <= {r_m[30:0], 1'b0};
            r_p <= r_p - 5'd1;
        end
        if (i_cmd.log_step) begin
            r_m    <= sq_top[32] ? sq_top[32:1] : sq_top[31:0];
            r_frac <= {r_frac[14:0], sq_top[32]};
            r_it   <= r_it + ITW'(1);
        end
        if (i_cmd.ln_mul) begin
            r_ln  <= ln_prod[52:32];
            r_neg <= l_val[31];
        end
        if (i_cmd.fe_mul) r_fmag <= fe_prod[36:8];
        if (i_cmd.out_emit) begin
            o_bin_index   <= r_min + 16'(r_k);
            o_density     <= r_zero ? '0 : r_dens;
            o_free_energy <= r_zero ? '0 : fe_val;
            o_overflow    <= r_ovf;
            o_last_bin    <= o_sts.emit_last;
        end
    end
endmodule
`default_nettype wire

### design/histogram_free_energy.sv
// Histogram free energy: loading takes one sample beat per cycle while not busy.
// The beat marked last starts a pass (or, with no stored samples, only clears the
// run state): set-up, bin clear, then index read, bin read and write per stored
// sample, then per occupied bin bit-serial divide, normalise and log2 squaring steps;
// an empty bin skips them. Results appear on o_valid for one cycle each; the receiver cannot stall.
// Synchronous active-low reset restores the configuration registers and clears the run state.
`default_nettype none
module histogram_free_energy #(
    parameter int MAX_SAMPLES = hfe_pkg::DEF_MAX_SAMPLES,
    parameter int MAX_BINS    = hfe_pkg::DEF_MAX_BINS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output      logic                                busy,
    input  wire logic                                i_cfg_we,
    input  wire logic [hfe_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [hfe_pkg::CFG_W-1:0]           i_cfg_data,
    input  wire logic signed [hfe_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic                                i_last,
    output      logic                                o_valid,
    output      logic signed [15:0]                  o_bin_index,
    output      logic [hfe_pkg::DENS_W-1:0]          o_density,
    output      logic signed [hfe_pkg::FE_W-1:0]     o_free_energy,
    output      logic                                o_overflow,
    output      logic                                o_last_bin
);
    import hfe_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer: owns the beat handshake and walks the run phases
    hfe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_last  (i_last),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // datapath: quantise and store on load, then clear, fill and emit bins
    hfe_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .MAX_BINS    (MAX_BINS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_sample      (i_sample),
        .o_valid       (o_valid),
        .o_bin_index   (o_bin_index),
        .o_density     (o_density),
        .o_free_energy (o_free_energy),
        .o_overflow    (o_overflow),
        .o_last_bin    (o_last_bin)
    );
endmodule
`default_nettype wire
